/* rtl/hsvg_pkg.sv */
// Shared types and constants for the HSV-to-RGB converter with gamma lookup.
// No dependencies; imported by hsvg_term and hsv_to_rgb_gamma.
package hsvg_pkg;

    localparam int unsigned HUE_W    = 9;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FRAC_W   = 6;   // hue remainder within a sector, 0..59
    localparam int unsigned SUB_W    = 13;  // sat * remainder, up to 6000
    localparam int unsigned TDATA_W  = 24;

    localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
    localparam logic [FRAC_W-1:0] SECTOR_DEG = 6'd60;
    localparam logic [SUB_W-1:0]  TERM_DEN   = 13'd6000;

    // Constant division by reciprocal multiply. Each reciprocal is rounded up
    // and the excess stays below one unit over the whole operand range.
    localparam logic [15:0] DIV100_RECIP  = 16'd41944;   // x/100, x <= 25500
    localparam int unsigned DIV100_SHIFT  = 22;
    localparam logic [10:0] DIV60_RECIP   = 11'd1093;    // x/60, x <= 511
    localparam int unsigned DIV60_SHIFT   = 16;
    localparam logic [19:0] DIV6000_RECIP = 20'd715828;  // x/6000, x <= 1530000
    localparam int unsigned DIV6000_SHIFT = 32;

    // Hue sector; hues of 360 and above fall into the last sector.
    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    // Stage enables for the scaled-term units; both instances take the same enables.
    typedef struct packed {
        logic mul_en;
        logic div_en;
    } term_ctrl_t;

    localparam logic [BYTE_W-1:0] GAMMA_ROM [256] = '{
        8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
        8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
        8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
        8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
        8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
        8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
        8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
        8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
        8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
        8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
        8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
        8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
        8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
        8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
        8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
        8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
        8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
        8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
        8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
        8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
        8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
        8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
        8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
        8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
        8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
    };

endpackage

/* rtl/hsvg_term.sv */
// Two-stage scaled term: floor(val * (6000 - sub) / 6000).
// Depends on hsvg_pkg for widths, the reciprocal and the stage-enable struct.
module hsvg_term (
    input  logic                             clk,
    input  hsvg_pkg::term_ctrl_t             ctrl,
    input  logic [hsvg_pkg::BYTE_W-1:0]      val,
    input  logic [hsvg_pkg::SUB_W-1:0]       sub,
    output logic [hsvg_pkg::BYTE_W-1:0]      term
);
    import hsvg_pkg::*;

    logic [20:0]       prod_reg;
    logic [20:0]       prod_next;
    logic [40:0]       quo_full;
    logic [BYTE_W-1:0] term_reg;
    logic [BYTE_W-1:0] term_next;

    // multiply stage: 8 x 13 bits
    assign prod_next = 21'(val) * 21'(TERM_DEN - sub);

    // divide stage: reciprocal multiply, 21 x 20 bits
    assign quo_full  = 41'(prod_reg) * 41'(DIV6000_RECIP);
    assign term_next = quo_full[DIV6000_SHIFT +: BYTE_W];

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.div_en)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

/* rtl/hsv_to_rgb_gamma.sv */
// Top level of the HSV-to-RGB converter with gamma-corrected brightness.
// Depends on hsvg_pkg and hsvg_term.
//
// Converts one hue / white / brightness beat into one RGB pixel beat. Brightness
// (clamped to 100) is scaled to a byte, bval = bright*255/100, and mapped through
// a 256-entry gamma table to give val. Saturation is 100 minus white (white
// clamped to 100). The hue picks a 60-degree sector and a remainder f; each
// channel is then val, floor(val*white/100), floor(val*(6000-sat*f)/6000) or
// floor(val*(6000-sat*(60-f))/6000), routed by sector. Hues of 360 and above
// use the last sector's routing. All divisions are exact integer truncation done
// by reciprocal multiplies. The datapath is a five-stage pipeline: input decode,
// gamma lookup and sat products, term multiplies, reciprocal divides, channel
// routing into the output register. It takes one beat per clock while the output
// is not stalled; m_tvalid is the valid bit of the output stage. Each stage
// carries a valid bit and holds under backpressure, so bubbles are squeezed out
// and a stalled output does not stop the input while earlier stages have room.
module hsv_to_rgb_gamma (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [8:0] hue_degrees, [15:9] white_percent, [22:16] bright_percent, [23] zero
    input  logic [hsvg_pkg::TDATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [hsvg_pkg::TDATA_W-1:0]      m_tdata
);
    import hsvg_pkg::*;

    localparam int unsigned STAGES = 5;

    // stage handshake
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] rdy;

    // input fields
    logic [HUE_W-1:0] hue_in;
    logic [PCT_W-1:0] white_in;
    logic [PCT_W-1:0] bright_in;

    // stage 1: decode
    logic [PCT_W-1:0]  white_c;
    logic [PCT_W-1:0]  bright_c;
    logic [14:0]       bright_x255;
    logic [30:0]       bval_prod;
    logic [19:0]       hue_prod;
    logic [3:0]        sector_raw;
    logic [9:0]        sector_base;
    sector_t           s1_sector_next;
    logic [FRAC_W-1:0] s1_f_next;
    logic [PCT_W-1:0]  s1_sat_next;
    logic [BYTE_W-1:0] s1_bval_next;
    sector_t           s1_sector_reg;
    logic [FRAC_W-1:0] s1_f_reg;
    logic [PCT_W-1:0]  s1_sat_reg;
    logic [PCT_W-1:0]  s1_white_reg;
    logic [BYTE_W-1:0] s1_bval_reg;

    // stage 2: gamma lookup and saturation products
    logic [BYTE_W-1:0] s2_val_next;
    logic [SUB_W-1:0]  s2_fall_sub_next;
    logic [SUB_W-1:0]  s2_rise_sub_next;
    sector_t           s2_sector_reg;
    logic [PCT_W-1:0]  s2_white_reg;
    logic [BYTE_W-1:0] s2_val_reg;
    logic [SUB_W-1:0]  s2_fall_sub_reg;
    logic [SUB_W-1:0]  s2_rise_sub_reg;

    // stage 3: multiplies
    logic [14:0]       s3_flat_prod_next;
    logic [14:0]       s3_flat_prod_reg;
    sector_t           s3_sector_reg;
    logic [BYTE_W-1:0] s3_val_reg;

    // stage 4: divides
    logic [30:0]       flat_quo;
    logic [BYTE_W-1:0] s4_flat_next;
    logic [BYTE_W-1:0] s4_flat_reg;
    sector_t           s4_sector_reg;
    logic [BYTE_W-1:0] s4_val_reg;
    logic [BYTE_W-1:0] falling;
    logic [BYTE_W-1:0] rising;
    term_ctrl_t        term_ctrl;

    // stage 5: output
    logic [BYTE_W-1:0] red_next;
    logic [BYTE_W-1:0] green_next;
    logic [BYTE_W-1:0] blue_next;
    logic [BYTE_W-1:0] red_reg;
    logic [BYTE_W-1:0] green_reg;
    logic [BYTE_W-1:0] blue_reg;

    // ---------------------------------------------------------------- control
    // A stage takes a new beat when empty or when the next stage moves.
    always_comb
    begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (rdy[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[STAGES-1];

    // ---------------------------------------------------------------- stage 1
    assign hue_in    = s_tdata[8:0];
    assign white_in  = s_tdata[15:9];
    assign bright_in = s_tdata[22:16];

    always_comb
    begin
        white_c  = (white_in > PCT_FULL) ? PCT_FULL : white_in;
        bright_c = (bright_in > PCT_FULL) ? PCT_FULL : bright_in;
        s1_sat_next = PCT_FULL - white_c;

        // bright*255 = bright*256 - bright, then /100
        bright_x255  = {bright_c, 8'd0} - 15'(bright_c);
        bval_prod    = 31'(bright_x255) * 31'(DIV100_RECIP);
        s1_bval_next = bval_prod[DIV100_SHIFT +: BYTE_W];

        // hue / 60 and hue mod 60
        hue_prod    = 20'(hue_in) * 20'(DIV60_RECIP);
        sector_raw  = hue_prod[DIV60_SHIFT +: 4];
        sector_base = 10'(sector_raw) * 10'(SECTOR_DEG);
        s1_f_next   = FRAC_W'(10'(hue_in) - sector_base);
        if (sector_raw > 4'(SECTOR_5))
        begin
            s1_sector_next = SECTOR_5;
        end
        else
        begin
            s1_sector_next = sector_t'(sector_raw[2:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_sector_reg <= s1_sector_next;
            s1_f_reg      <= s1_f_next;
            s1_sat_reg    <= s1_sat_next;
            s1_white_reg  <= white_c;
            s1_bval_reg   <= s1_bval_next;
        end
    end

    // ---------------------------------------------------------------- stage 2
    assign s2_val_next      = GAMMA_ROM[s1_bval_reg];
    assign s2_fall_sub_next = SUB_W'(s1_sat_reg) * SUB_W'(s1_f_reg);
    assign s2_rise_sub_next = SUB_W'(s1_sat_reg) * SUB_W'(SECTOR_DEG - s1_f_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s2_sector_reg   <= s1_sector_reg;
            s2_white_reg    <= s1_white_reg;
            s2_val_reg      <= s2_val_next;
            s2_fall_sub_reg <= s2_fall_sub_next;
            s2_rise_sub_reg <= s2_rise_sub_next;
        end
    end

    // ---------------------------------------------------------- stages 3 and 4
    assign term_ctrl.mul_en = rdy[2];
    assign term_ctrl.div_en = rdy[3];

    hsvg_term u_falling (
        .clk  (clk),
        .ctrl (term_ctrl),
        .val  (s2_val_reg),
        .sub  (s2_fall_sub_reg),
        .term (falling)
    );

    hsvg_term u_rising (
        .clk  (clk),
        .ctrl (term_ctrl),
        .val  (s2_val_reg),
        .sub  (s2_rise_sub_reg),
        .term (rising)
    );

    // flat term: val*(100-sat)/100 = val*white/100
    assign s3_flat_prod_next = 15'(s2_val_reg) * 15'(s2_white_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            s3_flat_prod_reg <= s3_flat_prod_next;
            s3_sector_reg    <= s2_sector_reg;
            s3_val_reg       <= s2_val_reg;
        end
    end

    assign flat_quo     = 31'(s3_flat_prod_reg) * 31'(DIV100_RECIP);
    assign s4_flat_next = flat_quo[DIV100_SHIFT +: BYTE_W];

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            s4_flat_reg   <= s4_flat_next;
            s4_sector_reg <= s3_sector_reg;
            s4_val_reg    <= s3_val_reg;
        end
    end

    // ---------------------------------------------------------------- stage 5
    always_comb
    begin
        case (s4_sector_reg)
            SECTOR_0:
            begin
                red_next   = s4_val_reg;
                green_next = rising;
                blue_next  = s4_flat_reg;
            end
            SECTOR_1:
            begin
                red_next   = falling;
                green_next = s4_val_reg;
                blue_next  = s4_flat_reg;
            end
            SECTOR_2:
            begin
                red_next   = s4_flat_reg;
                green_next = s4_val_reg;
                blue_next  = rising;
            end
            SECTOR_3:
            begin
                red_next   = s4_flat_reg;
                green_next = falling;
                blue_next  = s4_val_reg;
            end
            SECTOR_4:
            begin
                red_next   = rising;
                green_next = s4_flat_reg;
                blue_next  = s4_val_reg;
            end
            default:
            begin
                red_next   = s4_val_reg;
                green_next = s4_flat_reg;
                blue_next  = falling;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_tdata = {blue_reg, green_reg, red_reg};

endmodule
